// ===== src/aolq_pkg.sv =====
// Shared types and constants of the open-list priority queue.
package aolq_pkg;

    localparam int ROW_W  = 12;
    localparam int COL_W  = 12;
    localparam int TIME_W = 16;
    localparam int COST_W = 18;
    localparam int PAY_W  = 16;
    localparam int STAT_W = 3;
    localparam int CNTO_W = 9;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_INSERTED = 3'd0;
    localparam logic [STAT_W-1:0] STAT_REPLACED = 3'd1;
    localparam logic [STAT_W-1:0] STAT_KEPT     = 3'd2;
    localparam logic [STAT_W-1:0] STAT_EXTRACT  = 3'd3;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd4;
    localparam logic [STAT_W-1:0] STAT_FULL     = 3'd5;

    // Operation kinds
    localparam logic KIND_UPDATE  = 1'b0;
    localparam logic KIND_EXTRACT = 1'b1;

    // Register file
    localparam int              APB_AW        = 3;
    localparam int              APB_DW        = 32;
    localparam logic [APB_AW-1:0] ADDR_TIE_GMIN = 3'd0;

    // One stored entry
    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [TIME_W-1:0] istart;
        logic [TIME_W-1:0] iend;
        logic [COST_W-1:0] f;
        logic [COST_W-1:0] g;
        logic [PAY_W-1:0]  pay;
    } entry_t;

endpackage

// ===== src/aolq_if.sv =====
// Request and result channel interfaces of the open-list queue.
interface aolq_req_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [aolq_pkg::ROW_W-1:0]  row;
    logic [aolq_pkg::COL_W-1:0]  col;
    logic [aolq_pkg::TIME_W-1:0] interval_start;
    logic [aolq_pkg::TIME_W-1:0] interval_end;
    logic [aolq_pkg::COST_W-1:0] f_cost;
    logic [aolq_pkg::COST_W-1:0] g_cost;
    logic [aolq_pkg::PAY_W-1:0]  payload;

    modport source (output valid, kind, row, col, interval_start, interval_end,
                    f_cost, g_cost, payload, input ready);
    modport sink   (input valid, kind, row, col, interval_start, interval_end,
                    f_cost, g_cost, payload, output ready);
endinterface

interface aolq_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [aolq_pkg::STAT_W-1:0] status;
    logic [aolq_pkg::ROW_W-1:0]  out_row;
    logic [aolq_pkg::COL_W-1:0]  out_col;
    logic [aolq_pkg::TIME_W-1:0] out_interval_start;
    logic [aolq_pkg::TIME_W-1:0] out_interval_end;
    logic [aolq_pkg::COST_W-1:0] out_f_cost;
    logic [aolq_pkg::COST_W-1:0] out_g_cost;
    logic [aolq_pkg::PAY_W-1:0]  out_payload;
    logic [aolq_pkg::CNTO_W-1:0] count;

    modport source (output valid, status, out_row, out_col, out_interval_start,
                    out_interval_end, out_f_cost, out_g_cost, out_payload, count,
                    input ready);
    modport sink   (input valid, status, out_row, out_col, out_interval_start,
                    out_interval_end, out_f_cost, out_g_cost, out_payload, count,
                    output ready);
endinterface

// ===== src/astar_open_list_queue_core.sv =====
// Open-list priority queue with decrease-key, scanned by a small sequencer.
// Every operation walks all CAPACITY slots of the entry memory, one slot per
// cycle through its single read port. ST_SCAN steps through every slot, ST_LAST
// takes the last read and ST_COMMIT registers the result; the next request
// can transfer in the cycle after the commit, and no request is taken while
// one is in progress. The commit waits while an earlier result is still not
// taken.
// An update inserts a new key into the lowest free slot, or replaces a stored
// entry when the new f is smaller; an extract removes the least entry by
// f, g (direction set by tie_break_gmin at byte address 0), row, col and
// interval start, with the lower slot winning a full tie. Extract from an
// empty queue reports empty, insert of a new key into a full queue reports
// full and drops the key. Non-extract results carry zero entry fields.
module astar_open_list_queue_core #(
    parameter int CAPACITY = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    aolq_req_if.sink                       req,
    aolq_rsp_if.source                     rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [aolq_pkg::APB_AW-1:0]    paddr,
    input  logic [aolq_pkg::APB_DW-1:0]    pwdata,
    output logic [aolq_pkg::APB_DW-1:0]    prdata,
    output logic                           pready
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_LAST   = 4'b0100,
        ST_COMMIT = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic                  gmin_reg;
    logic [CAPACITY-1:0]   valid_reg;
    logic [CNT_W-1:0]      count_reg;

    logic                  kind_reg;
    aolq_pkg::entry_t      req_entry_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic                  pipe_vld_reg;
    logic                  pipe_bit_reg;
    logic [IDX_W-1:0]      pipe_idx_reg;

    logic                  hit_found_reg;
    logic [IDX_W-1:0]      hit_idx_reg;
    logic [aolq_pkg::COST_W-1:0] hit_f_reg;
    logic                  free_found_reg;
    logic [IDX_W-1:0]      free_idx_reg;
    logic                  best_found_reg;
    logic [IDX_W-1:0]      best_idx_reg;
    aolq_pkg::entry_t      best_entry_reg;

    logic                        rsp_valid_reg;
    logic [aolq_pkg::STAT_W-1:0] rsp_status_reg;
    aolq_pkg::entry_t            rsp_entry_reg;
    logic [aolq_pkg::CNTO_W-1:0] rsp_count_reg;

    aolq_pkg::entry_t      in_entry;
    aolq_pkg::entry_t      rd_entry;
    aolq_pkg::entry_t      cmp_other;
    logic                  key_match;
    logic                  goes_first;

    logic                  req_xfer;
    logic                  do_commit;
    logic                  upd_replace;
    logic                  upd_insert;
    logic                  ext_take;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [aolq_pkg::STAT_W-1:0] status_next;
    logic [CNT_W-1:0]      count_next;
    logic [CNT_W+aolq_pkg::CNTO_W-1:0] count_wide;

    // Configuration port
    assign pready = 1'b1;
    assign prdata = (paddr == aolq_pkg::ADDR_TIE_GMIN) ?
                    aolq_pkg::APB_DW'(gmin_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gmin_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready &&
                 (paddr == aolq_pkg::ADDR_TIE_GMIN))
        begin
            gmin_reg <= pwdata[0];
        end
    end

    // Input packing
    assign req.ready = (state_reg == ST_IDLE);
    assign req_xfer  = req.valid && req.ready;

    always_comb
    begin
        in_entry.row    = req.row;
        in_entry.col    = req.col;
        in_entry.istart = req.interval_start;
        in_entry.iend   = req.interval_end;
        in_entry.f      = req.f_cost;
        in_entry.g      = req.g_cost;
        in_entry.pay    = req.payload;
    end

    // Entry memory
    aolq_entry_mem #(
        .DEPTH (CAPACITY),
        .AW    (IDX_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (req_entry_reg),
        .raddr (idx_reg),
        .rdata (rd_entry)
    );

    // Shared compare unit: against the request on update, the best on extract
    assign cmp_other = kind_reg ? best_entry_reg : req_entry_reg;

    aolq_cmp u_cmp (
        .cand       (rd_entry),
        .other      (cmp_other),
        .gmin       (gmin_reg),
        .key_match  (key_match),
        .goes_first (goes_first)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (idx_reg == IDX_W'(CAPACITY - 1))
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (do_commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Latch the request and advance the slot index
    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            kind_reg      <= req.kind;
            req_entry_reg <= in_entry;
            idx_reg       <= '0;
        end
        else if (state_reg == ST_SCAN)
        begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
        pipe_idx_reg <= idx_reg;
        pipe_bit_reg <= valid_reg[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_vld_reg <= 1'b0;
        end
        else
        begin
            pipe_vld_reg <= (state_reg == ST_SCAN);
        end
    end

    // Scan step: track key hit, lowest free slot and least entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            best_found_reg <= 1'b0;
        end
        else if (req_xfer)
        begin
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            best_found_reg <= 1'b0;
        end
        else if (pipe_vld_reg)
        begin
            if (kind_reg == aolq_pkg::KIND_UPDATE)
            begin
                if (pipe_bit_reg && key_match && !hit_found_reg)
                begin
                    hit_found_reg <= 1'b1;
                end
                if (!pipe_bit_reg && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                end
            end
            else if (pipe_bit_reg && (!best_found_reg || goes_first))
            begin
                best_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_vld_reg)
        begin
            if (kind_reg == aolq_pkg::KIND_UPDATE)
            begin
                if (pipe_bit_reg && key_match && !hit_found_reg)
                begin
                    hit_idx_reg <= pipe_idx_reg;
                    hit_f_reg   <= rd_entry.f;
                end
                if (!pipe_bit_reg && !free_found_reg)
                begin
                    free_idx_reg <= pipe_idx_reg;
                end
            end
            else if (pipe_bit_reg && (!best_found_reg || goes_first))
            begin
                best_idx_reg   <= pipe_idx_reg;
                best_entry_reg <= rd_entry;
            end
        end
    end

    // Commit decision
    assign do_commit   = (state_reg == ST_COMMIT) && (!rsp_valid_reg || rsp.ready);
    assign upd_replace = (kind_reg == aolq_pkg::KIND_UPDATE) && hit_found_reg &&
                         (req_entry_reg.f < hit_f_reg);
    assign upd_insert  = (kind_reg == aolq_pkg::KIND_UPDATE) && !hit_found_reg &&
                         free_found_reg;
    assign ext_take    = (kind_reg == aolq_pkg::KIND_EXTRACT) && best_found_reg;
    assign mem_we      = do_commit && (upd_replace || upd_insert);
    assign mem_waddr   = hit_found_reg ? hit_idx_reg : free_idx_reg;

    always_comb
    begin
        count_next = count_reg;
        if (kind_reg == aolq_pkg::KIND_EXTRACT)
        begin
            if (best_found_reg)
            begin
                status_next = aolq_pkg::STAT_EXTRACT;
                count_next  = count_reg - CNT_W'(1);
            end
            else
            begin
                status_next = aolq_pkg::STAT_EMPTY;
            end
        end
        else if (hit_found_reg)
        begin
            status_next = upd_replace ? aolq_pkg::STAT_REPLACED : aolq_pkg::STAT_KEPT;
        end
        else if (free_found_reg)
        begin
            status_next = aolq_pkg::STAT_INSERTED;
            count_next  = count_reg + CNT_W'(1);
        end
        else
        begin
            status_next = aolq_pkg::STAT_FULL;
        end
    end

    assign count_wide = (CNT_W + aolq_pkg::CNTO_W)'(count_next);

    // Apply the step to occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
        end
        else if (do_commit)
        begin
            count_reg <= count_next;
            if (upd_insert)
            begin
                valid_reg[free_idx_reg] <= 1'b1;
            end
            if (ext_take)
            begin
                valid_reg[best_idx_reg] <= 1'b0;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (do_commit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_commit)
        begin
            rsp_status_reg <= status_next;
            rsp_entry_reg  <= ext_take ? best_entry_reg : '0;
            rsp_count_reg  <= count_wide[aolq_pkg::CNTO_W-1:0];
        end
    end

    assign rsp.valid              = rsp_valid_reg;
    assign rsp.status             = rsp_status_reg;
    assign rsp.out_row            = rsp_entry_reg.row;
    assign rsp.out_col            = rsp_entry_reg.col;
    assign rsp.out_interval_start = rsp_entry_reg.istart;
    assign rsp.out_interval_end   = rsp_entry_reg.iend;
    assign rsp.out_f_cost         = rsp_entry_reg.f;
    assign rsp.out_g_cost         = rsp_entry_reg.g;
    assign rsp.out_payload        = rsp_entry_reg.pay;
    assign rsp.count              = rsp_count_reg;

`ifndef ASSERT_OFF
    // Occupancy count tracks the valid bits
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(count_reg))
        else $error("occupancy count differs from valid bits");

    // Count never passes capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= CAPACITY)
        else $error("occupancy count above capacity");

    // An accepted request starts a scan
    a_accept_scans: assert property (@(posedge clk) disable iff (!rst_n)
        req_xfer |=> (state_reg == ST_SCAN) && !pipe_vld_reg)
        else $error("accepted request did not start a scan");

    // A commit always presents a result
    a_commit_result: assert property (@(posedge clk) disable iff (!rst_n)
        do_commit |=> rsp_valid_reg && (state_reg == ST_IDLE))
        else $error("commit without result");

    // No memory write outside the commit cycle
    a_write_commit: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_COMMIT))
        else $error("entry write outside commit");
`endif

endmodule

// ===== src/aolq_entry_mem.sv =====
// Entry store: one write port, one read port with registered read data.
module aolq_entry_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  aolq_pkg::entry_t wdata,
    input  logic [AW-1:0]    raddr,
    output aolq_pkg::entry_t rdata
);

    aolq_pkg::entry_t mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== src/aolq_cmp.sv =====
// Shared compare unit: key match and queue order of a scanned entry.
module aolq_cmp (
    input  aolq_pkg::entry_t cand,
    input  aolq_pkg::entry_t other,
    input  logic             gmin,
    output logic             key_match,
    output logic             goes_first
);

    // Key is row, column and the whole interval
    assign key_match = (cand.row == other.row) && (cand.col == other.col) &&
                       (cand.istart == other.istart) && (cand.iend == other.iend);

    // Order on f, then g per tie-break mode, then row, col, interval start
    always_comb
    begin
        if (cand.f != other.f)
        begin
            goes_first = cand.f < other.f;
        end
        else if (cand.g != other.g)
        begin
            goes_first = gmin ? (cand.g < other.g) : (cand.g > other.g);
        end
        else if (cand.row != other.row)
        begin
            goes_first = cand.row < other.row;
        end
        else if (cand.col != other.col)
        begin
            goes_first = cand.col < other.col;
        end
        else
        begin
            goes_first = cand.istart < other.istart;
        end
    end

endmodule

// ===== dv/tb_top.sv =====
// Testbench for the A* open-list queue: directed table, then random traffic checked by a predictor.
`timescale 1ns / 100ps

module tb_top;

    localparam int CAPACITY  = 256;
    localparam int HALF_CLK  = 6;
    localparam int IDLE_PCT  = 37;
    localparam int GAP_MAX   = CAPACITY + 16;
    localparam int WATCH_LIM = 10 * (CAPACITY + GAP_MAX);
    localparam int SHOW_MAX  = 10;

    typedef enum logic { ROW_ITEM, ROW_CFG } row_op_t;

    typedef struct packed {
        logic [aolq_pkg::STAT_W-1:0] status;
        aolq_pkg::entry_t            ent;
        logic [aolq_pkg::CNTO_W-1:0] count;
    } qres_t;

    typedef struct {
        row_op_t          op;
        logic             cfg_val;
        logic             kind;
        aolq_pkg::entry_t ent;
        logic             typed;
        qres_t            res;
    } dir_row_t;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [aolq_pkg::APB_AW-1:0] paddr;
    logic [aolq_pkg::APB_DW-1:0] pwdata;
    logic [aolq_pkg::APB_DW-1:0] prdata;
    logic                        pready;

    aolq_req_if req_ch ();
    aolq_rsp_if rsp_ch ();

    astar_open_list_queue_core #(
        .CAPACITY (CAPACITY)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #HALF_CLK clk = 1'b1;
        #HALF_CLK clk = 1'b0;
    end

    // Shadow copy of the open list
    logic             ol_valid [CAPACITY];
    aolq_pkg::entry_t ol_slot  [CAPACITY];
    int unsigned      ol_count;
    logic             ol_gmin;

    qres_t    pending_results[$];
    dir_row_t dir_q[$];
    int       fail_count  = 0;
    int       idle_cycles = 0;
    bit       calm        = 1'b0;

    // True when a is served before b; a full tie keeps the lower slot
    function automatic bit served_first(aolq_pkg::entry_t a, aolq_pkg::entry_t b);
        if (a.f != b.f) return a.f < b.f;
        if (a.g != b.g) return ol_gmin ? (a.g < b.g) : (a.g > b.g);
        if (a.row != b.row) return a.row < b.row;
        if (a.col != b.col) return a.col < b.col;
        return a.istart < b.istart;
    endfunction

    function automatic qres_t open_list_step(logic kind, aolq_pkg::entry_t n);
        qres_t r;
        int    hit;
        int    free_slot;
        int    best;
        r         = '0;
        hit       = -1;
        free_slot = -1;
        best      = -1;
        if (kind == aolq_pkg::KIND_UPDATE)
        begin
            // Find the stored key and the lowest free slot
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (ol_valid[i])
                begin
                    if (hit < 0 && {ol_slot[i].row, ol_slot[i].col, ol_slot[i].istart,
                                    ol_slot[i].iend} == {n.row, n.col, n.istart, n.iend})
                        hit = i;
                end
                else if (free_slot < 0)
                begin
                    free_slot = i;
                end
            end
            if (hit >= 0)
            begin
                if (n.f < ol_slot[hit].f)
                begin
                    ol_slot[hit] = n;
                    r.status     = aolq_pkg::STAT_REPLACED;
                end
                else
                begin
                    r.status = aolq_pkg::STAT_KEPT;
                end
            end
            else if (free_slot >= 0)
            begin
                ol_slot[free_slot]  = n;
                ol_valid[free_slot] = 1'b1;
                ol_count++;
                r.status = aolq_pkg::STAT_INSERTED;
            end
            else
            begin
                r.status = aolq_pkg::STAT_FULL;
            end
        end
        else
        begin
            // Pick the least entry
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (ol_valid[i] && (best < 0 || served_first(ol_slot[i], ol_slot[best])))
                    best = i;
            end
            if (best < 0)
            begin
                r.status = aolq_pkg::STAT_EMPTY;
            end
            else
            begin
                r.ent          = ol_slot[best];
                ol_valid[best] = 1'b0;
                ol_count--;
                r.status = aolq_pkg::STAT_EXTRACT;
            end
        end
        r.count = ol_count[aolq_pkg::CNTO_W-1:0];
        return r;
    endfunction

    function automatic aolq_pkg::entry_t mk_entry(int r, int c, int is, int ie, int f, int g,
                                                  int p);
        aolq_pkg::entry_t e;
        e.row    = aolq_pkg::ROW_W'(r);
        e.col    = aolq_pkg::COL_W'(c);
        e.istart = aolq_pkg::TIME_W'(is);
        e.iend   = aolq_pkg::TIME_W'(ie);
        e.f      = aolq_pkg::COST_W'(f);
        e.g      = aolq_pkg::COST_W'(g);
        e.pay    = aolq_pkg::PAY_W'(p);
        return e;
    endfunction

    function automatic aolq_pkg::entry_t rand_entry();
        return mk_entry($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    endfunction

    // Small key space so updates hit stored keys often
    function automatic aolq_pkg::entry_t pool_entry();
        return mk_entry($urandom_range(3), $urandom_range(3), $urandom_range(1),
                        $urandom_range(1), $urandom_range(63), $urandom_range(7), $urandom);
    endfunction

    // Wide keys, narrow costs: fills the list and piles up ties on f and g
    function automatic aolq_pkg::entry_t fill_entry();
        return mk_entry($urandom, $urandom, $urandom, $urandom,
                        $urandom_range(15), $urandom_range(3), $urandom);
    endfunction

    function automatic dir_row_t d_item(logic kind, aolq_pkg::entry_t e);
        dir_row_t d;
        d.op      = ROW_ITEM;
        d.cfg_val = 1'b0;
        d.kind    = kind;
        d.ent     = e;
        d.typed   = 1'b0;
        d.res     = '0;
        return d;
    endfunction

    function automatic dir_row_t d_typed(dir_row_t d, logic [aolq_pkg::STAT_W-1:0] st,
                                         aolq_pkg::entry_t e, int cnt);
        d.typed      = 1'b1;
        d.res.status = st;
        d.res.ent    = e;
        d.res.count  = aolq_pkg::CNTO_W'(cnt);
        return d;
    endfunction

    function automatic dir_row_t d_cfg(logic v);
        dir_row_t d;
        d         = d_item(aolq_pkg::KIND_UPDATE, '0);
        d.op      = ROW_CFG;
        d.cfg_val = v;
        return d;
    endfunction

    // Append one row to the directed table
    function automatic void add_row(dir_row_t d);
        dir_q.insert(dir_q.size(), d);
    endfunction

    task automatic flag_failure(string msg);
        fail_count++;
        if (fail_count <= SHOW_MAX)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // Drop valid and wait until every result has been taken
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // Write tie_break_gmin, then read it back
    task automatic set_tie_break(logic v);
        logic [aolq_pkg::APB_DW-1:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= aolq_pkg::ADDR_TIE_GMIN;
        pwdata  <= {{(aolq_pkg::APB_DW-1){1'b0}}, v};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        ol_gmin = v;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rd = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== {{(aolq_pkg::APB_DW-1){1'b0}}, v})
            flag_failure($sformatf("tie_break_gmin readback exp %0h act %0h", v, rd));
    endtask

    // Present one request, hold it until the transfer, record what it must return.
    // Called and returns at a falling edge.
    task automatic push_request(logic kind, aolq_pkg::entry_t e, logic typed,
                                qres_t typed_res);
        qres_t r;
        if (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            req_ch.valid <= 1'b0;
            if ($urandom_range(1))
                repeat ($urandom_range(1, 4)) @(negedge clk);
            else
                repeat ($urandom_range(1, GAP_MAX)) @(negedge clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.kind           <= kind;
        req_ch.row            <= e.row;
        req_ch.col            <= e.col;
        req_ch.interval_start <= e.istart;
        req_ch.interval_end   <= e.iend;
        req_ch.f_cost         <= e.f;
        req_ch.g_cost         <= e.g;
        req_ch.payload        <= e.pay;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        r = open_list_step(kind, e);
        pending_results.insert(pending_results.size(), typed ? typed_res : r);
        @(negedge clk);
    endtask

    // Result receiver stalls at random, except in calm stretches
    always @(negedge clk)
    begin
        rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // Check each result transfer against the oldest expectation
    always @(posedge clk)
    begin
        qres_t got;
        qres_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.status     = rsp_ch.status;
            got.ent.row    = rsp_ch.out_row;
            got.ent.col    = rsp_ch.out_col;
            got.ent.istart = rsp_ch.out_interval_start;
            got.ent.iend   = rsp_ch.out_interval_end;
            got.ent.f      = rsp_ch.out_f_cost;
            got.ent.g      = rsp_ch.out_g_cost;
            got.ent.pay    = rsp_ch.out_payload;
            got.count      = rsp_ch.count;
            if (pending_results.size() == 0)
            begin
                flag_failure($sformatf("result with nothing pending: status %0d count %0d",
                                       got.status, got.count));
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                    flag_failure($sformatf({"exp st %0d r %0h c %0h is %0h ie %0h f %0h g %0h ",
                                            "p %0h n %0d / act st %0d r %0h c %0h is %0h ",
                                            "ie %0h f %0h g %0h p %0h n %0d"},
                        want.status, want.ent.row, want.ent.col, want.ent.istart,
                        want.ent.iend, want.ent.f, want.ent.g, want.ent.pay, want.count,
                        got.status, got.ent.row, got.ent.col, got.ent.istart,
                        got.ent.iend, got.ent.f, got.ent.g, got.ent.pay, got.count));
            end
        end
    end

    // Watchdog: end the run after too long without any transfer
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIM)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        aolq_pkg::entry_t fill_keys[$];
        aolq_pkg::entry_t e;
        aolq_pkg::entry_t ze;
        aolq_pkg::entry_t maxe;
        aolq_pkg::entry_t maxr;

        // Drive every input to a known value
        rst_n                 = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        req_ch.valid          = 1'b0;
        req_ch.kind           = aolq_pkg::KIND_UPDATE;
        req_ch.row            = '0;
        req_ch.col            = '0;
        req_ch.interval_start = '0;
        req_ch.interval_end   = '0;
        req_ch.f_cost         = '0;
        req_ch.g_cost         = '0;
        req_ch.payload        = '0;
        rsp_ch.ready          = 1'b0;
        ol_count              = 0;
        ol_gmin               = 1'b0;
        for (int i = 0; i < CAPACITY; i++)
            ol_valid[i] = 1'b0;

        // Directed table: extremes, replace/keep, empty, then every tie-break level
        ze   = '0;
        maxe = mk_entry(4095, 4095, 65535, 65535, 262143, 262143, 65535);
        maxr = mk_entry(4095, 4095, 65535, 65535, 262142, 262143, 16'h5A5A);
        add_row(d_cfg(1'b0));
        add_row(d_typed(d_item(aolq_pkg::KIND_EXTRACT, rand_entry()),
                        aolq_pkg::STAT_EMPTY, '0, 0));
        add_row(d_typed(d_item(aolq_pkg::KIND_UPDATE, maxe), aolq_pkg::STAT_INSERTED, '0, 1));
        add_row(d_typed(d_item(aolq_pkg::KIND_UPDATE, ze), aolq_pkg::STAT_INSERTED, '0, 2));
        add_row(d_typed(d_item(aolq_pkg::KIND_UPDATE, mk_entry(0, 0, 0, 0, 0, 0, 65535)),
                        aolq_pkg::STAT_KEPT, '0, 2));
        add_row(d_typed(d_item(aolq_pkg::KIND_UPDATE, maxr), aolq_pkg::STAT_REPLACED, '0, 2));
        add_row(d_typed(d_item(aolq_pkg::KIND_EXTRACT, maxe), aolq_pkg::STAT_EXTRACT, ze, 1));
        add_row(d_typed(d_item(aolq_pkg::KIND_EXTRACT, ze), aolq_pkg::STAT_EXTRACT, maxr, 0));
        add_row(d_typed(d_item(aolq_pkg::KIND_EXTRACT, rand_entry()),
                        aolq_pkg::STAT_EMPTY, '0, 0));
        add_row(d_item(aolq_pkg::KIND_UPDATE, mk_entry(3, 3, 7, 10, 100, 5, 1)));
        add_row(d_item(aolq_pkg::KIND_UPDATE, mk_entry(3, 3, 7, 11, 100, 5, 2)));
        add_row(d_item(aolq_pkg::KIND_UPDATE, mk_entry(3, 3, 6, 10, 100, 5, 3)));
        add_row(d_item(aolq_pkg::KIND_UPDATE, mk_entry(3, 2, 7, 10, 100, 5, 4)));
        add_row(d_item(aolq_pkg::KIND_UPDATE, mk_entry(2, 9, 9, 9, 100, 5, 5)));
        add_row(d_item(aolq_pkg::KIND_UPDATE, mk_entry(9, 9, 9, 9, 100, 9, 6)));
        repeat (6)
            add_row(d_item(aolq_pkg::KIND_EXTRACT, rand_entry()));
        add_row(d_cfg(1'b1));
        add_row(d_item(aolq_pkg::KIND_UPDATE, mk_entry(0, 0, 1, 1, 50, 9, 7)));
        add_row(d_item(aolq_pkg::KIND_UPDATE, mk_entry(4095, 0, 1, 1, 50, 2, 8)));
        repeat (2)
            add_row(d_item(aolq_pkg::KIND_EXTRACT, rand_entry()));

        // Release reset on a falling edge
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Walk the directed table
        foreach (dir_q[i])
        begin
            if (dir_q[i].op == ROW_CFG)
            begin
                wait_drained();
                set_tie_break(dir_q[i].cfg_val);
            end
            else
            begin
                push_request(dir_q[i].kind, dir_q[i].ent, dir_q[i].typed, dir_q[i].res);
            end
        end

        // Mixed traffic on a small key space: inserts, replaces, keeps, extracts
        repeat (300)
        begin
            if ($urandom_range(99) < 40)
                push_request(aolq_pkg::KIND_EXTRACT, rand_entry(), 1'b0, '0);
            else
                push_request(aolq_pkg::KIND_UPDATE, pool_entry(), 1'b0, '0);
        end

        // Fill past capacity with no idling, then update stored keys while full
        wait_drained();
        set_tie_break(1'b0);
        calm = 1'b1;
        repeat (270)
        begin
            e = fill_entry();
            fill_keys.insert(fill_keys.size(), e);
            push_request(aolq_pkg::KIND_UPDATE, e, 1'b0, '0);
        end
        repeat (20)
        begin
            if ($urandom_range(99) < 70)
            begin
                e     = fill_keys[$urandom_range(fill_keys.size() - 1)];
                e.f   = aolq_pkg::COST_W'($urandom_range(15));
                e.g   = aolq_pkg::COST_W'($urandom_range(3));
                e.pay = aolq_pkg::PAY_W'($urandom);
            end
            else
            begin
                e = fill_entry();
            end
            push_request(aolq_pkg::KIND_UPDATE, e, 1'b0, '0);
        end

        // Drain to empty and beyond
        wait_drained();
        calm = 1'b0;
        set_tie_break(1'b1);
        repeat (280)
        begin
            if ($urandom_range(99) < 90)
                push_request(aolq_pkg::KIND_EXTRACT, rand_entry(), 1'b0, '0);
            else
                push_request(aolq_pkg::KIND_UPDATE, pool_entry(), 1'b0, '0);
        end

        // Noise: fully random fields
        wait_drained();
        set_tie_break(1'($urandom_range(1)));
        repeat (150)
        begin
            e = rand_entry();
            push_request(1'($urandom_range(1)), e, 1'b0, '0);
        end

        // Let the last results out, then hold a little longer for strays
        wait_drained();
        repeat (CAPACITY + 8) @(negedge clk);
        if (pending_results.size() != 0)
            flag_failure($sformatf("%0d results never arrived", pending_results.size()));

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
